@@ design/inline_frame_range_builder_defines.svh @@
// Assertion macros for the inline frame range builder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef INLINE_FRAME_RANGE_BUILDER_DEFINES_SVH
`define INLINE_FRAME_RANGE_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IFRB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ifrb check failed");

// Next-cycle implication, disabled in reset.
`define IFRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ifrb check failed");

`endif

@@ design/ifrb_pkg.sv @@
// Package for the inline frame range builder: sizes, register indexes,
// item and result types, memory request/response structs. No dependencies.
`timescale 1ns / 1ps

package ifrb_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 2);
    localparam int CFG_IDX_W = 2;

    localparam logic [DEPTH_W-1:0] MAX_DEPTH_V = DEPTH_W'(MAX_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LEN   = CFG_IDX_W'(1);

    typedef struct packed {
        logic [63:0] pc;
        logic [63:0] method_id;
        logic        has_frame;
        logic        frame_last;
        logic        record_last;
    } item_t;

    typedef struct packed {
        logic [63:0] range_method;
        logic [63:0] range_start;
        logic [63:0] range_end;
        logic        overflow;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] top_addr;
        logic [ADDR_W-1:0] cmp_addr;
    } mem_req_t;

    typedef struct packed {
        logic [63:0] top_method;
        logic [63:0] top_start;
        logic [63:0] cmp_method;
    } mem_rsp_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] frame_idx;
        logic               res_load;
    } ctrl_status_t;

endpackage

@@ design/ifrb_level_mem.sv @@
// Frame stack storage: method id and start pc per level, one write port,
// a top-of-stack read port and a compare read port. Depends on ifrb_pkg.
`timescale 1ns / 1ps

module ifrb_level_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  ifrb_pkg::mem_req_t req,
    input  logic [63:0]       wr_method,
    input  logic [63:0]       wr_start,
    output ifrb_pkg::mem_rsp_t rsp
);
    import ifrb_pkg::*;

    logic [63:0] method_mem [MAX_DEPTH];
    logic [63:0] start_mem  [MAX_DEPTH];

    logic [63:0] top_method_q;
    logic [63:0] top_start_q;
    logic [63:0] cmp_method_q;

    // write-through copies for a read that hits the entry written that cycle
    logic        fwd_top_reg;
    logic        fwd_cmp_reg;
    logic [63:0] fwd_method_reg;
    logic [63:0] fwd_start_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            method_mem[req.wr_addr] <= wr_method;
            start_mem[req.wr_addr]  <= wr_start;
        end
        top_method_q   <= method_mem[req.top_addr];
        top_start_q    <= start_mem[req.top_addr];
        cmp_method_q   <= method_mem[req.cmp_addr];
        fwd_method_reg <= wr_method;
        fwd_start_reg  <= wr_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_top_reg <= 1'b0;
            fwd_cmp_reg <= 1'b0;
        end
        else
        begin
            fwd_top_reg <= req.wr_en && (req.wr_addr == req.top_addr);
            fwd_cmp_reg <= req.wr_en && (req.wr_addr == req.cmp_addr);
        end
    end

    assign rsp.top_method = fwd_top_reg ? fwd_method_reg : top_method_q;
    assign rsp.top_start  = fwd_top_reg ? fwd_start_reg  : top_start_q;
    assign rsp.cmp_method = fwd_cmp_reg ? fwd_method_reg : cmp_method_q;

endmodule

@@ design/ifrb_ctrl.sv @@
// Sequencer: takes one item, compares/pushes its frame, pops closed levels
// one per cycle when slot_free, to the result reg. Depends on ifrb_pkg.
`timescale 1ns / 1ps

module ifrb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  ifrb_pkg::item_t        item_data,
    input  logic [63:0]            code_start,
    input  logic [31:0]            code_len,
    input  logic                   slot_free,
    output logic                   res_load,
    output ifrb_pkg::result_t      res_data,
    output ifrb_pkg::mem_req_t     mem_req,
    output logic [63:0]            mem_wr_method,
    output logic [63:0]            mem_wr_start,
    input  ifrb_pkg::mem_rsp_t     mem_rsp,
    output ifrb_pkg::ctrl_status_t status
);
    import ifrb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] fidx_reg, fidx_next;
    logic [DEPTH_W-1:0] keep_reg, keep_next;
    logic               ovf_reg, ovf_next;
    logic               push_pend_reg, push_pend_next;
    logic               fin_more_reg, fin_more_next;

    // latched item (payload, no reset)
    logic [63:0] pc_reg;
    logic [63:0] mid_reg;
    logic [63:0] end_pc_reg;
    logic        has_frame_reg;
    logic        frame_last_reg;
    logic        record_last_reg;

    logic               accept;
    logic               pos_in;
    logic               open_hit;
    logic               mismatch;
    logic               rec_end;
    logic [DEPTH_W-1:0] pos_inc;
    logic [DEPTH_W-1:0] count;
    logic [DEPTH_W-1:0] fin_keep;
    logic [DEPTH_W-1:0] depth_dec;
    logic               last_pop;
    logic               wr_en;
    logic [DEPTH_W-1:0] wr_pos;

    assign accept   = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);

    assign pos_in   = fidx_reg < MAX_DEPTH_V;
    assign open_hit = fidx_reg < depth_reg;
    assign mismatch = mem_rsp.cmp_method != mid_reg;
    assign pos_inc  = fidx_reg + DEPTH_W'(1);
    assign rec_end  = has_frame_reg ? frame_last_reg : 1'b1;
    assign count    = has_frame_reg ? pos_inc : fidx_reg;
    assign fin_keep = record_last_reg ? '0 : count;
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign last_pop  = (depth_dec == keep_reg);

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        fidx_next      = fidx_reg;
        keep_next      = keep_reg;
        ovf_next       = ovf_reg;
        push_pend_next = push_pend_reg;
        fin_more_next  = fin_more_reg;
        res_load       = 1'b0;
        wr_en          = 1'b0;
        wr_pos         = fidx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (has_frame_reg && !pos_in)
                begin
                    ovf_next = 1'b1;
                end
                if (rec_end)
                begin
                    fidx_next = '0;
                end
                else
                begin
                    fidx_next = (fidx_reg < MAX_DEPTH_V - DEPTH_W'(1)) ? pos_inc : MAX_DEPTH_V;
                end

                if (has_frame_reg && pos_in && open_hit && mismatch)
                begin
                    // close down to this level first, push afterwards
                    keep_next      = fidx_reg;
                    push_pend_next = 1'b1;
                    fin_more_next  = rec_end && record_last_reg;
                    state_next     = S_POP;
                end
                else
                begin
                    if (has_frame_reg && pos_in && !open_hit)
                    begin
                        wr_en      = 1'b1;
                        wr_pos     = fidx_reg;
                        depth_next = pos_inc;
                    end
                    push_pend_next = 1'b0;
                    fin_more_next  = 1'b0;
                    keep_next      = fin_keep;
                    if (rec_end && (depth_next > fin_keep))
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    depth_next = depth_dec;
                    if (last_pop)
                    begin
                        if (push_pend_reg)
                        begin
                            wr_en          = 1'b1;
                            wr_pos         = keep_reg;
                            depth_next     = keep_reg + DEPTH_W'(1);
                            push_pend_next = 1'b0;
                            if (fin_more_reg)
                            begin
                                keep_next     = '0;
                                fin_more_next = 1'b0;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            fidx_reg      <= '0;
            keep_reg      <= '0;
            ovf_reg       <= 1'b0;
            push_pend_reg <= 1'b0;
            fin_more_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            fidx_reg      <= fidx_next;
            keep_reg      <= keep_next;
            ovf_reg       <= ovf_next;
            push_pend_reg <= push_pend_next;
            fin_more_reg  <= fin_more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pc_reg          <= item_data.pc;
            mid_reg         <= item_data.method_id;
            has_frame_reg   <= item_data.has_frame;
            frame_last_reg  <= item_data.frame_last;
            record_last_reg <= item_data.record_last;
            end_pc_reg      <= item_data.record_last ? (code_start + {32'd0, code_len})
                                                     : item_data.pc;
        end
    end

    // top read follows the next depth so data is ready when the pop comes
    assign mem_req.wr_en    = wr_en;
    assign mem_req.wr_addr  = wr_pos[ADDR_W-1:0];
    assign mem_req.top_addr = (depth_next == '0) ? '0
                                                 : depth_next[ADDR_W-1:0] - ADDR_W'(1);
    assign mem_req.cmp_addr = pos_in ? fidx_reg[ADDR_W-1:0] : '0;
    assign mem_wr_method    = mid_reg;
    assign mem_wr_start     = pc_reg;

    assign res_data.range_method = mem_rsp.top_method;
    assign res_data.range_start  = mem_rsp.top_start;
    assign res_data.range_end    = end_pc_reg;
    assign res_data.overflow     = ovf_reg;
    assign res_data.run_last     = last_pop && !(push_pend_reg && fin_more_reg);

    assign status.depth     = depth_reg;
    assign status.frame_idx = fidx_reg;
    assign status.res_load  = res_load;

endmodule

@@ design/inline_frame_range_builder.sv @@
// Inline frame range builder, top level: config registers, result register,
// sequencer and frame stack memory. Depends on ifrb_pkg, ifrb_ctrl,
// ifrb_level_mem and inline_frame_range_builder_defines.svh.
//
// Usage:
//   item channel   : item_valid / item_stall / item_data, one frame per item,
//                    outermost frame first; has_frame=0 for an empty record.
//   result channel : result_valid / result_stall / result_data, one item per
//                    closed frame, deepest level first; run_last flags the
//                    last result caused by an input item.
//   config channel : cfg_valid / cfg_ready / cfg_index / cfg_data; index 0 is
//                    code_start, 1 is the code length (low 32 bits). Always
//                    ready; write only while the block is idle.
// Sequence: an item is accepted, compared/pushed in the stack memory
//   (S_EXEC), then closed levels pop one per cycle while the result slot is
//   free (S_POP), via the top-of-stack read port, into the output register.
// Stalls: a stalled result holds in the output register; popping waits.
// Reset: stack empty, overflow clear, config and control registers zero. Stack
//   contents and result data are not cleared; only open levels are ever read.
`timescale 1ns / 1ps
`include "inline_frame_range_builder_defines.svh"

module inline_frame_range_builder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  ifrb_pkg::item_t                   item_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output ifrb_pkg::result_t                 result_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ifrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data
);
    import ifrb_pkg::*;

    logic [63:0] code_start_reg;
    logic [31:0] code_len_reg;

    logic        result_valid_reg;
    result_t     result_data_reg;

    logic         slot_free;
    logic         res_load;
    result_t      res_data;
    mem_req_t     mem_req;
    mem_rsp_t     mem_rsp;
    logic [63:0]  mem_wr_method;
    logic [63:0]  mem_wr_start;
    ctrl_status_t status;

    // Config: always ready, writes land directly
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_start_reg <= '0;
            code_len_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CODE_START: code_start_reg <= cfg_data;
                CFG_CODE_LEN:   code_len_reg   <= cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    // Output register: loads only when empty or being drained
    assign slot_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_data_reg <= res_data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    ifrb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item_data     (item_data),
        .code_start    (code_start_reg),
        .code_len      (code_len_reg),
        .slot_free     (slot_free),
        .res_load      (res_load),
        .res_data      (res_data),
        .mem_req       (mem_req),
        .mem_wr_method (mem_wr_method),
        .mem_wr_start  (mem_wr_start),
        .mem_rsp       (mem_rsp),
        .status        (status)
    );

    ifrb_level_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .wr_method (mem_wr_method),
        .wr_start  (mem_wr_start),
        .rsp       (mem_rsp)
    );

    // Checks
    `IFRB_ASSERT_IMPL(a_depth_bound, 1'b1, status.depth <= MAX_DEPTH_V)
    `IFRB_ASSERT_IMPL(a_fidx_bound, 1'b1, status.frame_idx <= MAX_DEPTH_V)
    `IFRB_ASSERT_IMPL(a_no_overwrite, result_valid && result_stall, !status.res_load)
    `IFRB_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
    `IFRB_ASSERT_IMPL(a_pop_nonempty, status.res_load, status.depth != '0)

endmodule
